/* rtl/ssg_pkg.sv */
// Package for the stepper step generator: opcodes, driver modes, field widths
// and the packed layouts of the stream payloads.
// No dependencies; imported by every file of the block.
package ssg_pkg;

    localparam int TIMER_WIDTH_DEF = 16;

    localparam int PERIOD_W  = 16;
    localparam int TARGET_W  = 16;
    localparam int COUNT_W   = 17;
    localparam int PHASE_W   = 4;
    localparam int PHASE_IDX_W = 2;

    localparam int IN_TDATA_W  = 40;
    localparam int OUT_TDATA_W = 32;
    localparam int OPCODE_W    = 2;

    typedef enum logic [OPCODE_W-1:0] {
        OP_TICK = 2'd0,
        OP_MOVE = 2'd1,
        OP_SPIN = 2'd2,
        OP_STOP = 2'd3
    } opcode_t;

    typedef enum logic {
        MODE_STEP_DIR = 1'b0,
        MODE_WAVE     = 1'b1
    } drv_mode_t;

    // Input payload, lowest bit first: direction, period, step_target.
    typedef struct packed {
        logic [IN_TDATA_W-34:0] pad;
        logic [TARGET_W-1:0]    step_target;
        logic [PERIOD_W-1:0]    period;
        logic                   direction;
    } in_data_t;

    // Result payload, lowest bit first.
    typedef struct packed {
        logic [OUT_TDATA_W-26:0] pad;
        logic [COUNT_W-1:0]      steps_done;
        logic                    running;
        logic [PHASE_W-1:0]      phase_lines;
        logic                    enable_n;
        logic                    dir_out;
        logic                    step_pulse;
    } out_data_t;

endpackage

/* rtl/stepper_step_generator_unit.sv */
// Stepper step generator top level: command/tick stream in, pin-state stream out.
// Depends on ssg_pkg.
//
//  channel   | direction | handshake              | payload
//  ----------+-----------+------------------------+---------------------------------------
//  s_axis    | in        | s_axis_tvalid/tready   | tuser opcode, tdata dir/period/target
//  m_axis    | out       | m_axis_tvalid/tready   | tdata pin levels, running, steps_done
//  cfg       | in        | cfg_valid/cfg_ready    | cfg_data driver_mode
//
// One transfer in per cycle while m_axis is not stalled; its result shows on m_axis the next cycle.
// The motion state is updated in the accept cycle; the driver mode is written over cfg.
// Input is taken while the result register is empty or being drained.
// Reset clears the motion state, disables the driver and turns all coils off.
module stepper_step_generator_unit
    import ssg_pkg::*;
#(
    parameter int TIMER_WIDTH = TIMER_WIDTH_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,  // direction, period[15:0], step_target[15:0]
    input  logic [OPCODE_W-1:0]    s_axis_tuser,  // opcode
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,  // step_pulse, dir_out, enable_n,
                                                  // phase_lines[3:0], running, steps_done[16:0]
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic                   cfg_data
);

    in_data_t  in_data;
    opcode_t   opcode;
    logic      accept;

    drv_mode_t                mode_reg;
    logic                     run_reg, run_next;
    logic                     spin_reg, spin_next;
    logic [COUNT_W-1:0]       step_cnt_reg, step_cnt_next;
    logic [TARGET_W-1:0]      target_reg, target_next;
    logic [PHASE_IDX_W-1:0]   phase_idx_reg, phase_idx_next;
    logic                     dir_reg, dir_next;
    logic [TIMER_WIDTH-1:0]   period_reg, period_next;
    logic [TIMER_WIDTH-1:0]   tick_reg, tick_next;
    logic                     enable_reg, enable_next;
    logic [PHASE_W-1:0]       phase_reg, phase_next;
    logic                     pulse;
    logic [TIMER_WIDTH:0]     tick_sum;

    logic      out_valid_reg;
    out_data_t out_reg, out_next;

    assign in_data       = in_data_t'(s_axis_tdata);
    assign opcode        = opcode_t'(s_axis_tuser);
    assign s_axis_tready = !out_valid_reg || m_axis_tready;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign cfg_ready     = 1'b1;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_reg;

    assign tick_sum = {1'b0, tick_reg} + (TIMER_WIDTH+1)'(1);

    always_comb
    begin
        run_next       = run_reg;
        spin_next      = spin_reg;
        step_cnt_next  = step_cnt_reg;
        target_next    = target_reg;
        phase_idx_next = phase_idx_reg;
        dir_next       = dir_reg;
        period_next    = period_reg;
        tick_next      = tick_reg;
        enable_next    = enable_reg;
        phase_next     = phase_reg;
        pulse          = 1'b0;
        unique case (opcode)
            OP_TICK:
            begin
                if (run_reg)
                begin
                    // period zero acts as period one
                    if (tick_sum >= {1'b0, period_reg})
                    begin
                        tick_next = '0;
                        if (!spin_reg && (step_cnt_reg > {1'b0, target_reg}))
                        begin
                            // move finished: drop run, no step
                            run_next      = 1'b0;
                            step_cnt_next = '0;
                        end
                        else
                        begin
                            if (mode_reg == MODE_STEP_DIR)
                            begin
                                enable_next = 1'b0;
                                pulse       = 1'b1;
                            end
                            else
                            begin
                                phase_next = PHASE_W'(1) << phase_idx_reg;
                                phase_idx_next = dir_reg ? phase_idx_reg - PHASE_IDX_W'(1)
                                                         : phase_idx_reg + PHASE_IDX_W'(1);
                            end
                            if (!spin_reg)
                                step_cnt_next = step_cnt_reg + COUNT_W'(1);
                        end
                    end
                    else
                    begin
                        tick_next = tick_sum[TIMER_WIDTH-1:0];
                    end
                end
            end
            OP_MOVE:
            begin
                dir_next    = in_data.direction;
                period_next = TIMER_WIDTH'(in_data.period);
                tick_next   = '0;
                run_next    = 1'b1;
                spin_next   = 1'b0;
                target_next = in_data.step_target;
            end
            OP_SPIN:
            begin
                dir_next    = in_data.direction;
                period_next = TIMER_WIDTH'(in_data.period);
                tick_next   = '0;
                run_next    = 1'b1;
                spin_next   = 1'b1;
            end
            OP_STOP:
            begin
                run_next      = 1'b0;
                step_cnt_next = '0;
                target_next   = '0;
                period_next   = '0;
                tick_next     = '0;
            end
            default: ;
        endcase
    end

    always_comb
    begin
        out_next             = '0;
        out_next.step_pulse  = pulse;
        out_next.dir_out     = dir_next;
        out_next.enable_n    = enable_next;
        out_next.phase_lines = phase_next;
        out_next.running     = run_next;
        out_next.steps_done  = step_cnt_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= MODE_STEP_DIR;
            run_reg       <= 1'b0;
            spin_reg      <= 1'b0;
            step_cnt_reg  <= '0;
            target_reg    <= '0;
            phase_idx_reg <= '0;
            dir_reg       <= 1'b0;
            period_reg    <= '0;
            tick_reg      <= '0;
            enable_reg    <= 1'b1;
            phase_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                mode_reg <= drv_mode_t'(cfg_data);
            if (accept)
            begin
                run_reg       <= run_next;
                spin_reg      <= spin_next;
                step_cnt_reg  <= step_cnt_next;
                target_reg    <= target_next;
                phase_idx_reg <= phase_idx_next;
                dir_reg       <= dir_next;
                period_reg    <= period_next;
                tick_reg      <= tick_next;
                enable_reg    <= enable_next;
                phase_reg     <= phase_next;
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload needs no reset
    always_ff @(posedge clk)
    begin
        if (accept)
            out_reg <= out_next;
    end

endmodule

/* rtl/ssg_checker.sv */
// Port-level checker for the stepper step generator, bound to the top level.
// Depends on ssg_pkg and stepper_step_generator_unit.
module ssg_checker
    import ssg_pkg::*;
(
    input logic                   clk,
    input logic                   rst_n,
    input logic                   s_axis_tvalid,
    input logic                   s_axis_tready,
    input logic [OPCODE_W-1:0]    s_axis_tuser,
    input logic                   m_axis_tvalid,
    input logic                   m_axis_tready,
    input logic [OUT_TDATA_W-1:0] m_axis_tdata
);

    out_data_t res;
    assign res = out_data_t'(m_axis_tdata);

    // hold a stalled result
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    a_stop_clears: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready && (s_axis_tuser == OP_STOP)
        |=> m_axis_tvalid && !res.running && (res.steps_done == '0))
        else $error("stop did not clear motion state");

    a_cmd_no_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready && (s_axis_tuser != OP_TICK)
        |=> m_axis_tvalid && !res.step_pulse)
        else $error("command transfer produced a step pulse");

    a_pulse_enabled: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && res.step_pulse |-> !res.enable_n)
        else $error("step pulse with driver disabled");

    a_phase_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> $onehot0(res.phase_lines))
        else $error("coil lines not one-hot");

endmodule

bind stepper_step_generator_unit ssg_checker u_ssg_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

/* tb/stepper_step_generator_unit_test.sv */
// Self-checking testbench for stepper_step_generator_unit: directed and random
// command/tick streams, checked against an in-bench model of the step timing.
// Depends on ssg_pkg and the RTL of the block; needs no files or arguments.
module stepper_step_generator_unit_test
    import ssg_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 400_000;
    localparam int ITEMS_PER_PHASE = 325;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;   // direction, period[15:0], step_target[15:0]
    logic [OPCODE_W-1:0]    s_axis_tuser = OP_TICK; // opcode
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;        // step_pulse, dir_out, enable_n,
                                                 // phase_lines[3:0], running, steps_done[16:0]
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic                   cfg_data = 1'b0;

    int          src_idle_pct = 0;
    int          sink_stall_pct = 0;
    int          fail_count = 0;
    int          busy_items = 0;
    int unsigned cycle_count = 0;

    out_data_t   expected_pins[$];

    // Motor state as the block should hold it
    drv_mode_t   mode_q = MODE_STEP_DIR;
    logic        motor_on = 1'b0;
    logic        spin_on = 1'b0;
    logic [16:0] step_cnt = '0;
    logic [15:0] target_q = '0;
    logic [1:0]  phase_idx = '0;
    logic        dir_q = 1'b0;
    logic [15:0] period_q = '0;
    logic [15:0] tick_cnt = '0;
    logic        enable_q = 1'b1;
    logic [3:0]  coil_q = '0;

    stepper_step_generator_unit i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("stepper_step_generator_unit_test: FAIL");
            $finish;
        end
    end

    // One step event; returns the mode-0 pulse
    function automatic logic step_event();
        logic pulse;
        pulse = 1'b0;
        if (!spin_on && step_cnt > {1'b0, target_q})
        begin
            // move is past its target: halt instead of stepping
            motor_on = 1'b0;
            step_cnt = '0;
            return 1'b0;
        end
        if (mode_q == MODE_STEP_DIR)
        begin
            enable_q = 1'b0;
            pulse = 1'b1;
        end
        else
        begin
            coil_q = 4'b0001 << phase_idx;
            if (dir_q == 1'b0)
                phase_idx = phase_idx + 2'd1;
            else
                phase_idx = phase_idx - 2'd1;
        end
        if (!spin_on)
            step_cnt = step_cnt + 17'd1;
        return pulse;
    endfunction

    function automatic out_data_t predict_pins(opcode_t op, logic dir, logic [15:0] per,
                                               logic [15:0] tgt);
        out_data_t r;
        logic      pulse;
        pulse = 1'b0;
        case (op)
            OP_TICK:
            begin
                if (motor_on)
                begin
                    if ({1'b0, tick_cnt} + 17'd1 >= {1'b0, period_q})
                    begin
                        tick_cnt = '0;
                        pulse = step_event();
                    end
                    else
                        tick_cnt = tick_cnt + 16'd1;
                end
            end
            OP_MOVE, OP_SPIN:
            begin
                dir_q = dir;
                period_q = per;
                tick_cnt = '0;
                motor_on = 1'b1;
                spin_on = (op == OP_SPIN);
                if (op == OP_MOVE)
                    target_q = tgt;
            end
            default:
            begin
                motor_on = 1'b0;
                step_cnt = '0;
                target_q = '0;
                period_q = '0;
                tick_cnt = '0;
            end
        endcase
        r = '0;
        r.step_pulse = pulse;
        r.dir_out = dir_q;
        r.enable_n = enable_q;
        r.phase_lines = coil_q;
        r.running = motor_on;
        r.steps_done = step_cnt;
        return r;
    endfunction

    task automatic check_pins(out_data_t got);
        out_data_t want;
        if (expected_pins.size() == 0)
        begin
            $error("result transfer with no expected result: tdata %h", got);
            fail_count++;
        end
        else
        begin
            want = expected_pins.pop_front();
            if (got.step_pulse !== want.step_pulse)
            begin
                $error("step_pulse: expected %0d, got %0d", want.step_pulse, got.step_pulse);
                fail_count++;
            end
            if (got.dir_out !== want.dir_out)
            begin
                $error("dir_out: expected %0d, got %0d", want.dir_out, got.dir_out);
                fail_count++;
            end
            if (got.enable_n !== want.enable_n)
            begin
                $error("enable_n: expected %0d, got %0d", want.enable_n, got.enable_n);
                fail_count++;
            end
            if (got.phase_lines !== want.phase_lines)
            begin
                $error("phase_lines: expected %b, got %b", want.phase_lines, got.phase_lines);
                fail_count++;
            end
            if (got.running !== want.running)
            begin
                $error("running: expected %0d, got %0d", want.running, got.running);
                fail_count++;
            end
            if (got.steps_done !== want.steps_done)
            begin
                $error("steps_done: expected %0d, got %0d", want.steps_done, got.steps_done);
                fail_count++;
            end
        end
    endtask

    // Result side: check on each transfer, then pick the next ready level
    always @(posedge clk)
    begin
        if (m_axis_tvalid === 1'b1 && m_axis_tready)
            check_pins(m_axis_tdata);
        m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
    end

    task automatic send_cmd(opcode_t op, logic dir, logic [15:0] per, logic [15:0] tgt);
        in_data_t d;
        if (src_idle_pct != 0 && $urandom_range(99) < src_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < src_idle_pct);
        end
        d = '0;
        d.direction = dir;
        d.period = per;
        d.step_target = tgt;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= d;
        s_axis_tuser <= op;
        do
            @(posedge clk);
        while (!s_axis_tready);
        // ticks on a stopped motor do nothing and are not counted
        if (op != OP_TICK || motor_on)
            busy_items++;
        expected_pins.push_back(predict_pins(op, dir, per, tgt));
    endtask

    task automatic send_tick();
        send_cmd(OP_TICK, 1'($urandom_range(1)), 16'($urandom), 16'($urandom));
    endtask

    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        while (expected_pins.size() != 0)
            @(posedge clk);
        repeat (2) @(posedge clk);
    endtask

    task automatic write_driver_mode(drv_mode_t m);
        wait_idle();
        cfg_valid <= 1'b1;
        cfg_data <= m;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        mode_q = m;
    endtask

    function automatic logic [15:0] pick_period();
        int r;
        r = $urandom_range(99);
        if (r < 70)
            return 16'($urandom_range(3));
        else if (r < 90)
            return 16'($urandom_range(12, 4));
        else
            return 16'($urandom_range(65535));
    endfunction

    task automatic test_basic_commands();
        write_driver_mode(MODE_STEP_DIR);
        send_cmd(OP_TICK, 1'b1, 16'hFFFF, 16'hFFFF);   // stopped: nothing moves
        send_cmd(OP_MOVE, 1'b0, 16'd0, 16'd0);         // period zero acts as one
        repeat (3) send_tick();                        // one step, then the end of move
        send_cmd(OP_SPIN, 1'b1, 16'd1, 16'd0);
        repeat (2) send_tick();
        send_cmd(OP_STOP, 1'b1, 16'hFFFF, 16'hFFFF);
        send_cmd(OP_MOVE, 1'b1, 16'hFFFF, 16'hFFFF);
        send_tick();
        send_cmd(OP_STOP, 1'b0, 16'd0, 16'd0);
    endtask

    task automatic test_wave_drive();
        send_cmd(OP_SPIN, 1'b0, 16'd2, 16'd0);
        repeat (2) send_tick();
        // switch modes with the motor still running
        write_driver_mode(MODE_WAVE);
        repeat (5) send_tick();
        send_cmd(OP_SPIN, 1'b1, 16'd1, 16'd0);
        repeat (4) send_tick();
        send_cmd(OP_MOVE, 1'b0, 16'd1, 16'd1);
        repeat (4) send_tick();
        send_cmd(OP_STOP, 1'b1, 16'd0, 16'd0);
    endtask

    task automatic test_random_motion(drv_mode_t m, int src_pct, int sink_pct);
        int          pick;
        int          n_ticks;
        int          start;
        logic        dir;
        logic [15:0] per;
        logic [15:0] tgt;
        write_driver_mode(m);
        src_idle_pct = src_pct;
        sink_stall_pct = sink_pct;
        start = busy_items;
        while (busy_items - start < ITEMS_PER_PHASE)
        begin
            pick = $urandom_range(99);
            dir = 1'($urandom_range(1));
            per = pick_period();
            if (pick < 45)
            begin
                tgt = ($urandom_range(7) == 0) ? 16'($urandom) : 16'($urandom_range(6));
                send_cmd(OP_MOVE, dir, per, tgt);
                // run small moves to completion, poke at large ones
                if (tgt < 8 && per < 16)
                    n_ticks = (tgt + 2) * ((per == 0) ? 1 : per) + $urandom_range(2);
                else
                    n_ticks = $urandom_range(12, 1);
                repeat (n_ticks) send_tick();
            end
            else if (pick < 70)
            begin
                send_cmd(OP_SPIN, dir, per, 16'($urandom));
                repeat ($urandom_range(30, 1)) send_tick();
                if ($urandom_range(1))
                    send_cmd(OP_STOP, 1'($urandom_range(1)), 16'($urandom), 16'($urandom));
            end
            else if (pick < 80)
            begin
                send_cmd(OP_STOP, dir, 16'($urandom), 16'($urandom));
                repeat ($urandom_range(3)) send_tick();
            end
            else
                send_cmd(opcode_t'($urandom_range(3)), dir, 16'($urandom), 16'($urandom));
        end
    endtask

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_basic_commands();
        test_wave_drive();
        test_random_motion(MODE_WAVE, 0, 0);
        test_random_motion(MODE_STEP_DIR, 67, 0);
        test_random_motion(MODE_WAVE, 0, 67);
        test_random_motion(MODE_STEP_DIR, 32, 32);
        wait_idle();
        repeat (4) @(posedge clk);
        if (fail_count == 0)
            $display("stepper_step_generator_unit_test: PASS");
        else
            $display("stepper_step_generator_unit_test: FAIL");
        $finish;
    end

endmodule

/* sim.f */
rtl/ssg_pkg.sv
rtl/stepper_step_generator_unit.sv
rtl/ssg_checker.sv
tb/stepper_step_generator_unit_test.sv
